### hw/rtl/bpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared word formats, request and status codes, and controller states.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int PAGE_W        = 16;
	localparam int TOTAL_PAGES_W = 17;

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_USE   = 2'd2;
	localparam logic [1:0] REQ_AVAIL = 2'd3;

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_NOFREE = 2'd1;
	localparam logic [1:0] STATUS_RANGE  = 2'd2;

	localparam logic [TOTAL_PAGES_W-1:0] TOTAL_PAGES_RESET = 17'h10000;

	typedef struct packed {
		logic [1:0]               req_type;
		logic [PAGE_W-1:0]        first_page;
		logic [TOTAL_PAGES_W-1:0] end_page;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [PAGE_W-1:0] granted_page;
	} result_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SETUP,
		S_READ,
		S_EVAL
	} bpa_state_t;

endpackage

### hw/rtl/bpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/bitmap_page_allocator_next_fit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next-fit bitmap page allocator
// Allocates, frees and marks ranges of physical pages over a used-page bitmap.
// ----------------------------------------------------------------------------
// Usage:
// A request word is accepted on a rising edge with start high and busy low.
// It carries the request kind, a page number and a range end. Exactly one
// result word follows, shown on result for a single cycle with done high;
// the receiver cannot stall, so it must take the word in that cycle.
// The bitmap sits in a RAM of WORD_BITS-bit words, one bit per page, and
// every request that reaches it is a read-modify-write sweep over it: each
// word is read in S_READ, then checked and written back in S_EVAL. Allocate
// scans from the hint up to the page count, then wraps once to page zero and
// scans up to the hint. Free clears the bit of one page, and a free of a page
// beyond the page count is answered from S_IDLE without touching the RAM. A
// range sets or clears the bits in every word that it touches.
// After reset the block walks the RAM once, writing all ones so that every
// page reads as used, with busy high throughout. The total_pages register
// resets to 65536 and may be written through cfg_we and cfg_wdata
// while idle.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_next_fit #(
	parameter int MAX_PAGES = 65536,
	parameter int WORD_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  bpa_pkg::req_t                        req,
	output logic                                 busy,
	output logic                                 done,
	output bpa_pkg::result_t                     result,
	input  logic                                 cfg_we,
	input  logic [bpa_pkg::TOTAL_PAGES_W-1:0]    cfg_wdata
);

	import bpa_pkg::*;

	// Bitmap geometry. WORD_BITS is a power of two, so page to word and bit
	// is a plain split of the page number.
	localparam int DEPTH   = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BIT_W   = $clog2(WORD_BITS);
	localparam int CNT_W   = ($clog2(MAX_PAGES + 1) > TOTAL_PAGES_W) ?
	                         $clog2(MAX_PAGES + 1) : TOTAL_PAGES_W;
	localparam logic [CNT_W-1:0]   MAX_CNT   = CNT_W'(MAX_PAGES);
	localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(DEPTH - 1);

	bpa_state_t                 state_q, state_d;
	logic [TOTAL_PAGES_W-1:0]   total_pages_q;
	logic [CNT_W-1:0]           hint_q, hint_d;
	logic [1:0]                 op_q, op_d;
	logic                       phase_q, phase_d;
	logic [CNT_W-1:0]           lo_q, lo_d;
	logic [CNT_W-1:0]           hi_q, hi_d;
	logic [WADDR_W-1:0]         word_q, word_d;
	logic [WADDR_W-1:0]         last_q, last_d;
	logic [WADDR_W-1:0]         clr_q;
	logic                       done_q, done_d;
	result_t                    result_q, result_d;

	logic                       mem_we;
	logic [WADDR_W-1:0]         mem_waddr;
	logic [WORD_BITS-1:0]       mem_wdata;
	logic                       mem_re;
	logic [WORD_BITS-1:0]       rd_data;

	logic [CNT_W-1:0]           total_ext;
	logic [CNT_W-1:0]           pages;
	logic [CNT_W-1:0]           first_ext;
	logic [CNT_W-1:0]           end_ext;
	logic [CNT_W-1:0]           end_clip;
	logic [CNT_W-1:0]           hint_wrap;
	logic [CNT_W-1:0]           word_ext;
	logic [CNT_W-1:0]           lo_word;
	logic [CNT_W-1:0]           hi_word;
	logic [WORD_BITS-1:0]       range_mask;
	logic [WORD_BITS-1:0]       cand;
	logic                       found;
	logic [BIT_W-1:0]           found_idx;
	logic [CNT_W-1:0]           found_page;
	logic [WORD_BITS-1:0]       found_bit;
	logic [WORD_BITS-1:0]       lo_bit;
	logic                       word_last;
	logic                       accept;

	// Pages above MAX_PAGES do not exist, so the register is clipped.
	assign total_ext = CNT_W'(total_pages_q);
	assign pages     = (total_ext < MAX_CNT) ? total_ext : MAX_CNT;
	assign first_ext = CNT_W'(req.first_page);
	assign end_ext   = CNT_W'(req.end_page);
	assign end_clip  = (end_ext > pages) ? pages : end_ext;
	assign hint_wrap = (hint_q < pages) ? hint_q : pages;

	assign accept = start && (state_q == S_IDLE);

	// Which bits of the current word fall inside [lo, hi).
	assign word_ext = CNT_W'(word_q);
	assign lo_word  = lo_q >> BIT_W;
	assign hi_word  = hi_q >> BIT_W;

	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			range_mask[i] = ((word_ext > lo_word) || (BIT_W'(i) >= lo_q[BIT_W-1:0])) &&
			                ((word_ext < hi_word) || (BIT_W'(i) < hi_q[BIT_W-1:0]));
		end
	end

	// Lowest free page in range within the word just read.
	assign cand  = range_mask & ~rd_data;
	assign found = |cand;

	always_comb begin
		found_idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (cand[i]) begin
				found_idx = BIT_W'(i);
			end
		end
	end

	assign found_page = CNT_W'({word_q, found_idx});
	assign found_bit  = WORD_BITS'(1) << found_idx;
	assign lo_bit     = WORD_BITS'(1) << lo_q[BIT_W-1:0];
	assign word_last  = (word_q == last_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == LAST_WORD) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					unique case (req.req_type)
						REQ_FREE: state_d = (first_ext < pages) ? S_READ : S_IDLE;
						default:  state_d = S_SETUP;
					endcase
				end
			end
			S_SETUP: begin
				if (lo_q < hi_q) begin
					state_d = S_READ;
				end else if ((op_q == REQ_ALLOC) && !phase_q) begin
					state_d = S_SETUP;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_READ: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				unique case (op_q)
					REQ_ALLOC: begin
						if (found) begin
							state_d = S_IDLE;
						end else if (word_last) begin
							state_d = phase_q ? S_IDLE : S_SETUP;
						end else begin
							state_d = S_READ;
						end
					end
					REQ_FREE: state_d = S_IDLE;
					default:  state_d = word_last ? S_IDLE : S_READ;
				endcase
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Datapath, memory access and result.
	always_comb begin
		hint_d    = hint_q;
		op_d      = op_q;
		phase_d   = phase_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		word_d    = word_q;
		last_d    = last_q;
		done_d    = 1'b0;
		result_d  = result_q;
		mem_we    = 1'b0;
		mem_waddr = word_q;
		mem_wdata = rd_data;
		mem_re    = 1'b0;

		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '1;
			end
			S_IDLE: begin
				if (accept) begin
					op_d    = req.req_type;
					phase_d = 1'b0;
					unique case (req.req_type)
						REQ_ALLOC: begin
							lo_d = hint_q;
							hi_d = pages;
						end
						REQ_FREE: begin
							lo_d   = first_ext;
							word_d = WADDR_W'(first_ext >> BIT_W);
							if (first_ext >= pages) begin
								done_d                = 1'b1;
								result_d.status       = STATUS_RANGE;
								result_d.granted_page = '0;
							end
						end
						default: begin
							lo_d = first_ext;
							hi_d = end_clip;
						end
					endcase
				end
			end
			S_SETUP: begin
				if (lo_q < hi_q) begin
					word_d = WADDR_W'(lo_q >> BIT_W);
					last_d = WADDR_W'((hi_q - CNT_W'(1)) >> BIT_W);
				end else if ((op_q == REQ_ALLOC) && !phase_q) begin
					// Nothing above the hint: wrap and scan up to it.
					phase_d = 1'b1;
					lo_d    = '0;
					hi_d    = hint_wrap;
				end else begin
					done_d                = 1'b1;
					result_d.status       = (op_q == REQ_ALLOC) ? STATUS_NOFREE : STATUS_OK;
					result_d.granted_page = '0;
				end
			end
			S_READ: begin
				mem_re = 1'b1;
			end
			S_EVAL: begin
				unique case (op_q)
					REQ_ALLOC: begin
						if (found) begin
							mem_we                = 1'b1;
							mem_wdata             = rd_data | found_bit;
							hint_d                = found_page;
							done_d                = 1'b1;
							result_d.status       = STATUS_OK;
							result_d.granted_page = PAGE_W'(found_page);
						end else if (word_last) begin
							if (phase_q) begin
								done_d                = 1'b1;
								result_d.status       = STATUS_NOFREE;
								result_d.granted_page = '0;
							end else begin
								phase_d = 1'b1;
								lo_d    = '0;
								hi_d    = hint_wrap;
							end
						end else begin
							word_d = word_q + WADDR_W'(1);
						end
					end
					REQ_FREE: begin
						mem_we    = 1'b1;
						mem_wdata = rd_data & ~lo_bit;
						if (lo_q < hint_q) begin
							hint_d = lo_q;
						end
						done_d                = 1'b1;
						result_d.status       = STATUS_OK;
						result_d.granted_page = '0;
					end
					default: begin
						mem_we    = 1'b1;
						mem_wdata = (op_q == REQ_USE) ? (rd_data | range_mask)
						                              : (rd_data & ~range_mask);
						if (word_last) begin
							done_d                = 1'b1;
							result_d.status       = STATUS_OK;
							result_d.granted_page = '0;
						end else begin
							word_d = word_q + WADDR_W'(1);
						end
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			total_pages_q <= TOTAL_PAGES_RESET;
			hint_q        <= '0;
			clr_q         <= '0;
			done_q        <= 1'b0;
			op_q          <= REQ_ALLOC;
			phase_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			hint_q  <= hint_d;
			done_q  <= done_d;
			op_q    <= op_d;
			phase_q <= phase_d;
			if (cfg_we) begin
				total_pages_q <= cfg_wdata;
			end
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + WADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		word_q   <= word_d;
		last_q   <= last_d;
		result_q <= result_d;
	end

	bpa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH)
	) u_bitmap (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (word_q),
		.rdata (rd_data)
	);

	assign busy   = !(state_q == S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule
